>>> rtl/mrarm_pkg.sv
// Shared types, constants and codes for the modular range add / range min block.
package mrarm_pkg;

    localparam int MAX_ELEMENTS_DEF = 1024;

    localparam int IDX_W     = 11;
    localparam int VAL_W     = 31;
    localparam int MOD_W     = 32;
    localparam int FUNC_W    = 2;
    localparam int CFG_IDX_W = 1;

    localparam logic [MOD_W-1:0] MOD_RESET   = 32'd1000000007;
    localparam logic [MOD_W-1:0] MOD_LIMIT   = 32'h8000_0000;
    localparam logic [MOD_W-1:0] MOD_FLOOR   = 32'd1;
    localparam int               COUNT_RESET = 1024;

    localparam logic [FUNC_W-1:0] FUNC_LOAD = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_ADD  = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_MIN  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_MODULUS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_COUNT   = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_ADDEND,
        ST_CHECK,
        ST_REDUCE,
        ST_APPLY
    } state_t;

    typedef enum logic [1:0] {
        RES_BAD,
        RES_EMPTY,
        RES_MIN
    } res_kind_t;

    typedef struct packed {
        logic      capture;
        logic      read_start;
        logic      step_next;
        logic      mem_write_load;
        logic      mem_write_add;
        logic      div_start;
        logic      div_from_rdata;
        logic      addend_from_opv;
        logic      addend_from_rem;
        logic      elem_from_rdata;
        logic      elem_from_rem;
        logic      best_init;
        logic      best_update;
        logic      emit;
        res_kind_t res_kind;
    } cmd_t;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic              bad_load;
        logic              bad_range;
        logic              empty;
        logic              opv_lt_m;
        logic              rdata_lt_m;
        logic              div_done;
        logic              last;
    } status_t;

endpackage

>>> rtl/mrarm_rem.sv
// Bit-serial restoring remainder unit, one dividend bit per cycle.
module mrarm_rem
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [mrarm_pkg::VAL_W-1:0]   dividend,
    input  logic [mrarm_pkg::MOD_W-1:0]   divisor,
    output logic                          done,
    output logic [mrarm_pkg::VAL_W-1:0]   remainder
);

    localparam int CNT_W = $clog2(mrarm_pkg::VAL_W);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(mrarm_pkg::VAL_W - 1);

    logic                          busy_reg;
    logic                          done_reg;
    logic [CNT_W-1:0]              cnt_reg;
    logic [mrarm_pkg::VAL_W-1:0]   dvd_reg;
    logic [mrarm_pkg::VAL_W-1:0]   rem_reg;
    logic [mrarm_pkg::MOD_W-1:0]   trial;
    logic [mrarm_pkg::VAL_W-1:0]   rem_next;

    assign trial = {rem_reg, dvd_reg[mrarm_pkg::VAL_W-1]};

    always_comb
    begin
        if (trial >= divisor)
        begin
            rem_next = mrarm_pkg::VAL_W'(trial - divisor);
        end
        else
        begin
            rem_next = trial[mrarm_pkg::VAL_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_LAST)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg <= dividend;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            dvd_reg <= {dvd_reg[mrarm_pkg::VAL_W-2:0], 1'b0};
            rem_reg <= rem_next;
        end
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule

>>> rtl/mrarm_dp.sv
// Datapath: configuration, item registers, element store, modular add and running minimum.
module mrarm_dp
#(
    parameter int MAX_ELEMENTS = mrarm_pkg::MAX_ELEMENTS_DEF
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_valid,
    input  logic [mrarm_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [mrarm_pkg::MOD_W-1:0]       cfg_data,
    input  logic [mrarm_pkg::FUNC_W-1:0]      func,
    input  logic [mrarm_pkg::IDX_W-1:0]       range_start,
    input  logic [mrarm_pkg::IDX_W-1:0]       range_end,
    input  logic [mrarm_pkg::VAL_W-1:0]       operand_value,
    input  mrarm_pkg::cmd_t                   cmd,
    output mrarm_pkg::status_t                stat,
    output logic [mrarm_pkg::VAL_W-1:0]       min_value,
    output logic                              range_empty,
    output logic                              bad_request
);

    localparam int ADDR_W = (MAX_ELEMENTS > 2) ? $clog2(MAX_ELEMENTS) : 1;
    localparam int IDX_W  = mrarm_pkg::IDX_W;
    localparam int VAL_W  = mrarm_pkg::VAL_W;
    localparam int MOD_W  = mrarm_pkg::MOD_W;
    localparam logic [IDX_W-1:0] CNT_RST = (mrarm_pkg::COUNT_RESET > MAX_ELEMENTS)
                                           ? IDX_W'(MAX_ELEMENTS)
                                           : IDX_W'(mrarm_pkg::COUNT_RESET);

    logic [MOD_W-1:0]                 mod_reg;
    logic [IDX_W-1:0]                 count_reg;
    logic [mrarm_pkg::FUNC_W-1:0]     func_reg;
    logic [IDX_W-1:0]                 start_reg;
    logic [IDX_W-1:0]                 end_reg;
    logic [VAL_W-1:0]                 opv_reg;
    logic [IDX_W-1:0]                 idx_reg;
    logic [VAL_W-1:0]                 rdata_reg;
    logic [VAL_W-1:0]                 elem_reg;
    logic [VAL_W-1:0]                 addend_reg;
    logic [VAL_W-1:0]                 best_reg;
    logic [VAL_W-1:0]                 min_value_reg;
    logic                             range_empty_reg;
    logic                             bad_request_reg;
    logic [VAL_W-1:0]                 store_mem [MAX_ELEMENTS];

    logic [MOD_W-1:0]                 mod_clamp;
    logic [IDX_W-1:0]                 cnt_clamp;
    logic [IDX_W-1:0]                 idx_inc;
    logic [MOD_W-1:0]                 sum_raw;
    logic [VAL_W-1:0]                 sum_mod;
    logic [VAL_W-1:0]                 best_min;
    logic                             mem_we;
    logic                             mem_re;
    logic [ADDR_W-1:0]                waddr;
    logic [ADDR_W-1:0]                raddr;
    logic [VAL_W-1:0]                 wdata;
    logic [VAL_W-1:0]                 dvd_in;
    logic                             div_done;
    logic [VAL_W-1:0]                 div_rem;

    always_comb
    begin
        if (cfg_data == '0)
        begin
            mod_clamp = mrarm_pkg::MOD_FLOOR;
        end
        else if (cfg_data > mrarm_pkg::MOD_LIMIT)
        begin
            mod_clamp = mrarm_pkg::MOD_LIMIT;
        end
        else
        begin
            mod_clamp = cfg_data;
        end
        if (32'(cfg_data[IDX_W-1:0]) > 32'(MAX_ELEMENTS))
        begin
            cnt_clamp = IDX_W'(MAX_ELEMENTS);
        end
        else
        begin
            cnt_clamp = cfg_data[IDX_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mod_reg   <= mrarm_pkg::MOD_RESET;
            count_reg <= CNT_RST;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                mrarm_pkg::REG_MODULUS: mod_reg   <= mod_clamp;
                mrarm_pkg::REG_COUNT:   count_reg <= cnt_clamp;
                default:                mod_reg   <= mod_reg;
            endcase
        end
    end

    assign idx_inc  = idx_reg + IDX_W'(1);
    assign sum_raw  = {1'b0, elem_reg} + {1'b0, addend_reg};
    assign sum_mod  = (sum_raw >= mod_reg) ? VAL_W'(sum_raw - mod_reg) : sum_raw[VAL_W-1:0];
    assign best_min = (elem_reg < best_reg) ? elem_reg : best_reg;

    assign stat.func       = func_reg;
    assign stat.bad_load   = (start_reg >= count_reg) || ({1'b0, opv_reg} >= mod_reg);
    assign stat.bad_range  = end_reg > count_reg;
    assign stat.empty      = start_reg >= end_reg;
    assign stat.opv_lt_m   = {1'b0, opv_reg} < mod_reg;
    assign stat.rdata_lt_m = {1'b0, rdata_reg} < mod_reg;
    assign stat.div_done   = div_done;
    assign stat.last       = idx_inc == end_reg;

    assign mem_we = cmd.mem_write_load | cmd.mem_write_add;
    assign mem_re = cmd.read_start | cmd.step_next;
    assign waddr  = cmd.mem_write_add ? ADDR_W'(idx_reg) : ADDR_W'(start_reg);
    assign wdata  = cmd.mem_write_add ? sum_mod : opv_reg;
    assign raddr  = cmd.step_next ? ADDR_W'(idx_inc) : ADDR_W'(start_reg);
    assign dvd_in = cmd.div_from_rdata ? rdata_reg : opv_reg;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            store_mem[waddr] <= wdata;
        end
        if (mem_re)
        begin
            rdata_reg <= store_mem[raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            func_reg  <= func;
            start_reg <= range_start;
            end_reg   <= range_end;
            opv_reg   <= operand_value;
        end
        if (cmd.read_start)
        begin
            idx_reg <= start_reg;
        end
        else if (cmd.step_next)
        begin
            idx_reg <= idx_inc;
        end
        if (cmd.addend_from_opv)
        begin
            addend_reg <= opv_reg;
        end
        else if (cmd.addend_from_rem)
        begin
            addend_reg <= div_rem;
        end
        if (cmd.elem_from_rdata)
        begin
            elem_reg <= rdata_reg;
        end
        else if (cmd.elem_from_rem)
        begin
            elem_reg <= div_rem;
        end
        if (cmd.best_init)
        begin
            best_reg <= '1;
        end
        else if (cmd.best_update)
        begin
            best_reg <= best_min;
        end
        if (cmd.emit)
        begin
            unique case (cmd.res_kind)
                mrarm_pkg::RES_BAD:
                begin
                    min_value_reg   <= '0;
                    range_empty_reg <= 1'b0;
                    bad_request_reg <= 1'b1;
                end
                mrarm_pkg::RES_EMPTY:
                begin
                    min_value_reg   <= '0;
                    range_empty_reg <= 1'b1;
                    bad_request_reg <= 1'b0;
                end
                mrarm_pkg::RES_MIN:
                begin
                    min_value_reg   <= best_min;
                    range_empty_reg <= 1'b0;
                    bad_request_reg <= 1'b0;
                end
                default:
                begin
                    min_value_reg   <= '0;
                    range_empty_reg <= 1'b0;
                    bad_request_reg <= 1'b0;
                end
            endcase
        end
    end

    mrarm_rem u_rem
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (cmd.div_start),
        .dividend  (dvd_in),
        .divisor   (mod_reg),
        .done      (div_done),
        .remainder (div_rem)
    );

    assign min_value   = min_value_reg;
    assign range_empty = range_empty_reg;
    assign bad_request = bad_request_reg;

endmodule

>>> rtl/mrarm_ctrl.sv
// Controller state machine: sequences each item over the element range.
module mrarm_ctrl
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    output logic                  out_valid,
    input  logic                  out_ready,
    input  mrarm_pkg::status_t    stat,
    output mrarm_pkg::cmd_t       cmd
);

    mrarm_pkg::state_t state_reg;
    mrarm_pkg::state_t state_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic              out_free;

    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            mrarm_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = mrarm_pkg::ST_DECODE;
                end
            end
            mrarm_pkg::ST_DECODE:
            begin
                unique case (stat.func)
                    mrarm_pkg::FUNC_LOAD:
                    begin
                        if (!stat.bad_load || out_free)
                        begin
                            state_next = mrarm_pkg::ST_IDLE;
                        end
                    end
                    mrarm_pkg::FUNC_ADD:
                    begin
                        priority if (stat.bad_range)
                        begin
                            if (out_free)
                            begin
                                state_next = mrarm_pkg::ST_IDLE;
                            end
                        end
                        else if (stat.empty)
                        begin
                            state_next = mrarm_pkg::ST_IDLE;
                        end
                        else if (stat.opv_lt_m)
                        begin
                            state_next = mrarm_pkg::ST_CHECK;
                        end
                        else
                        begin
                            state_next = mrarm_pkg::ST_ADDEND;
                        end
                    end
                    mrarm_pkg::FUNC_MIN:
                    begin
                        if (stat.bad_range || stat.empty)
                        begin
                            if (out_free)
                            begin
                                state_next = mrarm_pkg::ST_IDLE;
                            end
                        end
                        else
                        begin
                            state_next = mrarm_pkg::ST_CHECK;
                        end
                    end
                    default:
                    begin
                        state_next = mrarm_pkg::ST_IDLE;
                    end
                endcase
            end
            mrarm_pkg::ST_ADDEND:
            begin
                if (stat.div_done)
                begin
                    state_next = mrarm_pkg::ST_CHECK;
                end
            end
            mrarm_pkg::ST_CHECK:
            begin
                state_next = stat.rdata_lt_m ? mrarm_pkg::ST_APPLY : mrarm_pkg::ST_REDUCE;
            end
            mrarm_pkg::ST_REDUCE:
            begin
                if (stat.div_done)
                begin
                    state_next = mrarm_pkg::ST_APPLY;
                end
            end
            mrarm_pkg::ST_APPLY:
            begin
                priority if (!stat.last)
                begin
                    state_next = mrarm_pkg::ST_CHECK;
                end
                else if (stat.func != mrarm_pkg::FUNC_MIN || out_free)
                begin
                    state_next = mrarm_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = mrarm_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd          = '0;
        cmd.res_kind = mrarm_pkg::RES_MIN;
        unique case (state_reg)
            mrarm_pkg::ST_IDLE:
            begin
                cmd.capture = in_valid;
            end
            mrarm_pkg::ST_DECODE:
            begin
                unique case (stat.func)
                    mrarm_pkg::FUNC_LOAD:
                    begin
                        if (!stat.bad_load)
                        begin
                            cmd.mem_write_load = 1'b1;
                        end
                        else
                        begin
                            cmd.emit     = out_free;
                            cmd.res_kind = mrarm_pkg::RES_BAD;
                        end
                    end
                    mrarm_pkg::FUNC_ADD:
                    begin
                        priority if (stat.bad_range)
                        begin
                            cmd.emit     = out_free;
                            cmd.res_kind = mrarm_pkg::RES_BAD;
                        end
                        else if (!stat.empty)
                        begin
                            cmd.read_start      = 1'b1;
                            cmd.addend_from_opv = stat.opv_lt_m;
                            cmd.div_start       = !stat.opv_lt_m;
                        end
                    end
                    mrarm_pkg::FUNC_MIN:
                    begin
                        priority if (stat.bad_range)
                        begin
                            cmd.emit     = out_free;
                            cmd.res_kind = mrarm_pkg::RES_BAD;
                        end
                        else if (stat.empty)
                        begin
                            cmd.emit     = out_free;
                            cmd.res_kind = mrarm_pkg::RES_EMPTY;
                        end
                        else
                        begin
                            cmd.read_start = 1'b1;
                            cmd.best_init  = 1'b1;
                        end
                    end
                    default:
                    begin
                        cmd.capture = 1'b0;
                    end
                endcase
            end
            mrarm_pkg::ST_ADDEND:
            begin
                cmd.addend_from_rem = stat.div_done;
            end
            mrarm_pkg::ST_CHECK:
            begin
                cmd.elem_from_rdata = stat.rdata_lt_m;
                cmd.div_start       = !stat.rdata_lt_m;
                cmd.div_from_rdata  = 1'b1;
            end
            mrarm_pkg::ST_REDUCE:
            begin
                cmd.elem_from_rem = stat.div_done;
            end
            mrarm_pkg::ST_APPLY:
            begin
                cmd.mem_write_add = stat.func == mrarm_pkg::FUNC_ADD;
                cmd.best_update   = stat.func == mrarm_pkg::FUNC_MIN;
                cmd.step_next     = !stat.last;
                cmd.emit          = stat.last && stat.func == mrarm_pkg::FUNC_MIN && out_free;
                cmd.res_kind      = mrarm_pkg::RES_MIN;
            end
            default:
            begin
                cmd.capture = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        priority if (cmd.emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= mrarm_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = state_reg == mrarm_pkg::ST_IDLE;
    assign out_valid = out_valid_reg;

endmodule

>>> rtl/modular_range_add_range_min_top.sv
// Top level of the modular range add / range minimum block.
// A range add or min walks its elements one by one; the bit-serial remainder unit
// reduces each element whose stored value is not below the modulus, and also the addend
// of a range add when it is not below it. An item with a result holds its last cycle
// while the result register stays full.
// Reset clears control state and restores modulus and count; the store is not cleared.
module modular_range_add_range_min_top
#(
    parameter int MAX_ELEMENTS = mrarm_pkg::MAX_ELEMENTS_DEF
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [mrarm_pkg::FUNC_W-1:0]      func,
    input  logic [mrarm_pkg::IDX_W-1:0]       range_start,
    input  logic [mrarm_pkg::IDX_W-1:0]       range_end,
    input  logic [mrarm_pkg::VAL_W-1:0]       operand_value,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [mrarm_pkg::VAL_W-1:0]       min_value,
    output logic                              range_empty,
    output logic                              bad_request,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [mrarm_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [mrarm_pkg::MOD_W-1:0]       cfg_data
);

    mrarm_pkg::cmd_t    cmd;
    mrarm_pkg::status_t stat;

    assign cfg_ready = 1'b1;

    mrarm_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    mrarm_dp #(
        .MAX_ELEMENTS (MAX_ELEMENTS)
    ) u_dp
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .func          (func),
        .range_start   (range_start),
        .range_end     (range_end),
        .operand_value (operand_value),
        .cmd           (cmd),
        .stat          (stat),
        .min_value     (min_value),
        .range_empty   (range_empty),
        .bad_request   (bad_request)
    );

endmodule

>>> rtl/mrarm_checker.sv
// Port-level assertions for the modular range add / range minimum block, with bind.
module mrarm_checker
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    input  logic                              in_ready,
    input  logic [mrarm_pkg::FUNC_W-1:0]      func,
    input  logic [mrarm_pkg::IDX_W-1:0]       range_start,
    input  logic [mrarm_pkg::IDX_W-1:0]       range_end,
    input  logic [mrarm_pkg::VAL_W-1:0]       operand_value,
    input  logic                              out_valid,
    input  logic                              out_ready,
    input  logic [mrarm_pkg::VAL_W-1:0]       min_value,
    input  logic                              range_empty,
    input  logic                              bad_request,
    input  logic                              cfg_valid,
    input  logic                              cfg_ready,
    input  logic [mrarm_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [mrarm_pkg::MOD_W-1:0]       cfg_data
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(min_value)
                                    && $stable(range_empty) && $stable(bad_request))
        else $error("result item dropped or changed while stalled");

    a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(range_empty && bad_request))
        else $error("result item flags both empty and bad");

    a_flag_zero_value: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (range_empty || bad_request) |-> min_value == '0)
        else $error("flagged result item carries a value");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("second item accepted before decode");

endmodule

bind modular_range_add_range_min_top mrarm_checker u_mrarm_checker (.*);

>>> test/tb.sv
// Self-checking testbench for the modular range add / range minimum block.
module tb;

    localparam int IDX_W = mrarm_pkg::IDX_W;
    localparam int VAL_W = mrarm_pkg::VAL_W;
    localparam int MOD_W = mrarm_pkg::MOD_W;
    localparam int FUNC_W = mrarm_pkg::FUNC_W;
    localparam int CFG_IDX_W = mrarm_pkg::CFG_IDX_W;
    localparam int MAX_ELEMENTS = mrarm_pkg::MAX_ELEMENTS_DEF;
    localparam int ADDR_W = $clog2(MAX_ELEMENTS);
    localparam logic [FUNC_W-1:0] FUNC_SPARE = 2'd3;
    localparam logic [VAL_W-1:0] VAL_MAX = '1;
    localparam int STALL_LIMIT = 200000;
    localparam int PHASES = 10;
    localparam int PHASE_ITEMS = 58;

    typedef struct packed {
        logic [VAL_W-1:0] minv;
        logic             empty;
        logic             bad;
    } answer_t;

    typedef struct {
        logic [FUNC_W-1:0] f;
        logic [IDX_W-1:0]  s;
        logic [IDX_W-1:0]  e;
        logic [VAL_W-1:0]  v;
        bit                typed;
        answer_t           a;
    } step_t;

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_ready;
    logic [FUNC_W-1:0]    func;
    logic [IDX_W-1:0]     range_start;
    logic [IDX_W-1:0]     range_end;
    logic [VAL_W-1:0]     operand_value;
    logic                 out_valid;
    logic                 out_ready;
    logic [VAL_W-1:0]     min_value;
    logic                 range_empty;
    logic                 bad_request;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [MOD_W-1:0]     cfg_data;

    bit [VAL_W-1:0] shadow_store [MAX_ELEMENTS];
    bit             shadow_loaded [MAX_ELEMENTS];
    bit [MOD_W-1:0] mod_reg = mrarm_pkg::MOD_RESET;
    bit [IDX_W-1:0] count_reg = IDX_W'(mrarm_pkg::COUNT_RESET);

    answer_t answers_due [$];
    step_t   plan [$];
    int      faults = 0;
    int      results_seen = 0;
    int      idle_cycles = 0;
    int      send_streak = 0;
    bit      send_quiet = 0;
    int      recv_streak = 0;
    bit      recv_quiet = 0;

    modular_range_add_range_min_top #(
        .MAX_ELEMENTS(MAX_ELEMENTS)
    ) i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .func(func),
        .range_start(range_start),
        .range_end(range_end),
        .operand_value(operand_value),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .min_value(min_value),
        .range_empty(range_empty),
        .bad_request(bad_request),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic longint unsigned live_mod();
        if (mod_reg == '0)
            return 64'd1;
        if (mod_reg > mrarm_pkg::MOD_LIMIT)
            return 64'(mrarm_pkg::MOD_LIMIT);
        return 64'(mod_reg);
    endfunction

    function automatic longint unsigned live_count();
        if (32'(count_reg) > MAX_ELEMENTS)
            return 64'(MAX_ELEMENTS);
        return 64'(count_reg);
    endfunction

    function automatic int pace(inout int streak, inout bit quiet);
        if (streak == 0)
        begin
            streak = int'($urandom_range(40, 4));
            quiet = ($urandom_range(3, 0) == 0);
        end
        streak--;
        return quiet ? 0 : int'($urandom_range(14, 0));
    endfunction

    task automatic apply_request(input logic [FUNC_W-1:0] f, input logic [IDX_W-1:0] s,
                                 input logic [IDX_W-1:0] e, input logic [VAL_W-1:0] v);
        longint unsigned m;
        longint unsigned n;
        longint unsigned addend;
        longint unsigned x;
        longint unsigned best;
        answer_t a;
        begin
            m = live_mod();
            n = live_count();
            a = '0;
            case (f)
                mrarm_pkg::FUNC_LOAD:
                begin
                    if (64'(s) >= n || 64'(v) >= m)
                    begin
                        a.bad = 1'b1;
                        answers_due.push_back(a);
                    end
                    else
                    begin
                        shadow_store[ADDR_W'(s)] = v;
                        shadow_loaded[ADDR_W'(s)] = 1'b1;
                    end
                end
                mrarm_pkg::FUNC_ADD:
                begin
                    if (64'(e) > n)
                    begin
                        a.bad = 1'b1;
                        answers_due.push_back(a);
                    end
                    else
                    begin
                        addend = 64'(v) % m;
                        for (int i = int'(s); i < int'(e); i++)
                        begin
                            x = (64'(shadow_store[ADDR_W'(i)]) % m + addend) % m;
                            shadow_store[ADDR_W'(i)] = x[VAL_W-1:0];
                        end
                    end
                end
                mrarm_pkg::FUNC_MIN:
                begin
                    if (64'(e) > n)
                        a.bad = 1'b1;
                    else if (s >= e)
                        a.empty = 1'b1;
                    else
                    begin
                        best = 64'(VAL_MAX);
                        for (int i = int'(s); i < int'(e); i++)
                        begin
                            x = 64'(shadow_store[ADDR_W'(i)]) % m;
                            if (x < best)
                                best = x;
                        end
                        a.minv = best[VAL_W-1:0];
                    end
                    answers_due.push_back(a);
                end
                default:
                begin
                    a = '0;
                end
            endcase
        end
    endtask

    task automatic offer(input logic [FUNC_W-1:0] f, input logic [IDX_W-1:0] s,
                         input logic [IDX_W-1:0] e, input logic [VAL_W-1:0] v,
                         input bit typed, input answer_t a);
        int gap;
        begin
            gap = pace(send_streak, send_quiet);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            in_valid <= 1'b1;
            func <= f;
            range_start <= s;
            range_end <= e;
            operand_value <= v;
            @(posedge clk);
            while (!in_ready)
                @(posedge clk);
            apply_request(f, s, e, v);
            if (typed)
                answers_due[answers_due.size() - 1] = a;
        end
    endtask

    task automatic settle();
        begin
            in_valid <= 1'b0;
            @(posedge clk);
            while (!in_ready || answers_due.size() != 0)
                @(posedge clk);
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [MOD_W-1:0] data);
        begin
            cfg_valid <= 1'b1;
            cfg_index <= idx;
            cfg_data <= data;
            @(posedge clk);
            while (!cfg_ready)
                @(posedge clk);
            if (idx == mrarm_pkg::REG_MODULUS)
                mod_reg = data;
            else
                count_reg = data[IDX_W-1:0];
        end
    endtask

    task automatic configure(input logic [MOD_W-1:0] m, input logic [MOD_W-1:0] c);
        begin
            settle();
            write_reg(mrarm_pkg::REG_MODULUS, m);
            write_reg(mrarm_pkg::REG_COUNT, c);
            cfg_valid <= 1'b0;
        end
    endtask

    task automatic row(input logic [FUNC_W-1:0] f, input int s, input int e,
                       input logic [VAL_W-1:0] v, input bit typed, input answer_t a);
        step_t st;
        begin
            st.f = f;
            st.s = s[IDX_W-1:0];
            st.e = e[IDX_W-1:0];
            st.v = v;
            st.typed = typed;
            st.a = a;
            plan.push_back(st);
        end
    endtask

    task automatic random_phase(input int items);
        logic [FUNC_W-1:0] f;
        logic [IDX_W-1:0]  s;
        logic [IDX_W-1:0]  e;
        logic [VAL_W-1:0]  v;
        longint unsigned   m;
        longint unsigned   n;
        longint unsigned   t;
        int                ni;
        int                r;
        int                hole;
        bit                pause;
        begin
            pause = $urandom_range(1, 0) != 0;
            for (int j = 0; j < items; j++)
            begin
                if (pause && j == items / 2)
                begin
                    in_valid <= 1'b0;
                    @(posedge clk);
                    while (answers_due.size() != 0)
                        @(posedge clk);
                end
                m = live_mod();
                n = live_count();
                ni = int'(n);
                r = int'($urandom_range(99, 0));
                f = (r < 35) ? mrarm_pkg::FUNC_LOAD :
                    (r < 65) ? mrarm_pkg::FUNC_ADD :
                    (r < 97) ? mrarm_pkg::FUNC_MIN : FUNC_SPARE;

                r = int'($urandom_range(99, 0));
                if (r < 3)
                begin
                    s = '0;
                    e = n[IDX_W-1:0];
                end
                else if (r < 10)
                begin
                    e = IDX_W'($urandom_range(2047, ni + 1));
                    s = IDX_W'($urandom_range(2047, 0));
                end
                else if (r < 17)
                begin
                    e = IDX_W'($urandom_range(ni, 0));
                    s = IDX_W'($urandom_range(2047, 32'(e)));
                end
                else if (n == 0)
                begin
                    s = IDX_W'($urandom_range(2047, 0));
                    e = '0;
                end
                else
                begin
                    s = IDX_W'($urandom_range(ni - 1, 0));
                    t = 64'(s) + 64'($urandom_range(16, 1));
                    e = (t > n) ? n[IDX_W-1:0] : t[IDX_W-1:0];
                end
                if (f == mrarm_pkg::FUNC_LOAD && n > 0 && $urandom_range(99, 0) < 85)
                    s = IDX_W'($urandom_range(ni - 1, 0));

                r = int'($urandom_range(99, 0));
                if (r < 60)
                    t = 64'($urandom()) % m;
                else if (r < 75)
                    t = 64'($urandom() & 32'h7FFF_FFFF);
                else if (r < 85)
                    t = (m - 64'd1) & 64'h7FFF_FFFF;
                else
                    t = ($urandom_range(1, 0) != 0) ? 64'h7FFF_FFFF : 64'd0;
                v = t[VAL_W-1:0];

                if ((f == mrarm_pkg::FUNC_ADD || f == mrarm_pkg::FUNC_MIN)
                    && 64'(e) <= n && s < e)
                begin
                    hole = -1;
                    for (int i = int'(s); i < int'(e) && hole < 0; i++)
                        if (!shadow_loaded[ADDR_W'(i)])
                            hole = i;
                    if (hole >= 0)
                    begin
                        f = mrarm_pkg::FUNC_LOAD;
                        s = IDX_W'(hole);
                        t = 64'($urandom()) % m;
                        v = t[VAL_W-1:0];
                    end
                end
                offer(f, s, e, v, 1'b0, '0);
            end
        end
    endtask

    initial
    begin
        bit held;
        int gap;
        answer_t want;
        held = 0;
        out_ready <= 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (results_seen == 120 && !held)
            begin
                held = 1;
                out_ready <= 1'b0;
                repeat (400) @(posedge clk);
            end
            gap = pace(recv_streak, recv_quiet);
            if (gap > 0)
            begin
                out_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid)
                @(posedge clk);
            results_seen++;
            if (answers_due.size() == 0)
            begin
                $error("unexpected item: min_value %0d range_empty %0d bad_request %0d",
                       min_value, range_empty, bad_request);
                faults++;
            end
            else
            begin
                want = answers_due.pop_front();
                if (min_value !== want.minv)
                begin
                    $error("min_value: expected %0d, got %0d", want.minv, min_value);
                    faults++;
                end
                if (range_empty !== want.empty)
                begin
                    $error("range_empty: expected %0d, got %0d", want.empty, range_empty);
                    faults++;
                end
                if (bad_request !== want.bad)
                begin
                    $error("bad_request: expected %0d, got %0d", want.bad, bad_request);
                    faults++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
                idle_cycles <= 0;
            else if (idle_cycles >= STALL_LIMIT)
            begin
                $display("status: fail");
                $finish;
            end
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    initial
    begin
        logic [MOD_W-1:0] phase_mod [PHASES];
        logic [MOD_W-1:0] phase_count [PHASES];
        answer_t bad;
        answer_t empty;
        answer_t none;
        rst_n <= 1'b0;
        in_valid <= 1'b0;
        func <= mrarm_pkg::FUNC_LOAD;
        range_start <= '0;
        range_end <= '0;
        operand_value <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= mrarm_pkg::REG_MODULUS;
        cfg_data <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        configure(mrarm_pkg::MOD_RESET, MOD_W'(mrarm_pkg::COUNT_RESET));

        bad = '{minv: '0, empty: 1'b0, bad: 1'b1};
        empty = '{minv: '0, empty: 1'b1, bad: 1'b0};
        none = '0;
        row(mrarm_pkg::FUNC_LOAD, 0, 0, 31'd0, 1'b0, none);
        row(mrarm_pkg::FUNC_LOAD, 1023, 0, 31'd1000000006, 1'b0, none);
        row(mrarm_pkg::FUNC_LOAD, 1, 0, 31'd5, 1'b0, none);
        row(mrarm_pkg::FUNC_MIN, 0, 2, 31'd0, 1'b1, none);
        row(mrarm_pkg::FUNC_MIN, 1023, 1024, 31'd0, 1'b1,
            '{minv: 31'd1000000006, empty: 1'b0, bad: 1'b0});
        row(mrarm_pkg::FUNC_LOAD, 2, 0, 31'd1000000007, 1'b1, bad);
        row(mrarm_pkg::FUNC_LOAD, 2, 2047, 31'h7FFF_FFFF, 1'b1, bad);
        row(mrarm_pkg::FUNC_LOAD, 1024, 0, 31'd3, 1'b1, bad);
        row(mrarm_pkg::FUNC_LOAD, 2047, 0, 31'd3, 1'b1, bad);
        row(mrarm_pkg::FUNC_ADD, 0, 2, 31'h7FFF_FFFF, 1'b0, none);
        row(mrarm_pkg::FUNC_MIN, 0, 2, 31'd0, 1'b0, none);
        row(mrarm_pkg::FUNC_ADD, 1023, 1024, 31'd1, 1'b0, none);
        row(mrarm_pkg::FUNC_MIN, 1023, 1024, 31'd0, 1'b1, none);
        row(mrarm_pkg::FUNC_MIN, 1, 1, 31'd0, 1'b1, empty);
        row(mrarm_pkg::FUNC_MIN, 5, 3, 31'd0, 1'b1, empty);
        row(mrarm_pkg::FUNC_ADD, 7, 2, 31'd9, 1'b0, none);
        row(mrarm_pkg::FUNC_ADD, 0, 1025, 31'd4, 1'b1, bad);
        row(mrarm_pkg::FUNC_MIN, 0, 2047, 31'd0, 1'b1, bad);
        row(mrarm_pkg::FUNC_MIN, 2047, 2047, 31'h7FFF_FFFF, 1'b1, bad);
        row(FUNC_SPARE, 2047, 2047, 31'h7FFF_FFFF, 1'b0, none);
        row(mrarm_pkg::FUNC_ADD, 0, 0, 31'd0, 1'b0, none);
        row(mrarm_pkg::FUNC_LOAD, 1022, 0, 31'd0, 1'b0, none);
        row(mrarm_pkg::FUNC_MIN, 1022, 1024, 31'd0, 1'b0, none);
        row(mrarm_pkg::FUNC_MIN, 0, 1, 31'd0, 1'b0, none);
        foreach (plan[k])
            offer(plan[k].f, plan[k].s, plan[k].e, plan[k].v, plan[k].typed, plan[k].a);

        phase_mod[0] = mrarm_pkg::MOD_LIMIT;             phase_count[0] = 32'd1024;
        phase_mod[1] = 32'd2;                            phase_count[1] = 32'd16;
        phase_mod[2] = 32'd7;                            phase_count[2] = 32'd1;
        phase_mod[3] = 32'd0;                            phase_count[3] = 32'd2;
        phase_mod[4] = 32'hFFFF_FFFF;                    phase_count[4] = 32'd2047;
        phase_mod[5] = 32'd1000;                         phase_count[5] = 32'd0;
        phase_mod[6] = $urandom_range(32'h8000_0000, 2); phase_count[6] = 32'd64;
        phase_mod[7] = 32'h7FFF_FFFF;                    phase_count[7] = 32'd1024;
        phase_mod[8] = 32'd1;                            phase_count[8] = 32'd1023;
        phase_mod[9] = $urandom_range(50, 2);            phase_count[9] = 32'hFFFF_F810;
        for (int k = 0; k < PHASES; k++)
        begin
            configure(phase_mod[k], phase_count[k]);
            random_phase(PHASE_ITEMS);
        end

        settle();
        repeat (100) @(posedge clk);
        if (faults == 0 && answers_due.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
